// ===== hdl/assert_macros.svh =====
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== hdl/ppsch_pkg.sv =====
// types, constants and helpers for the preemptive priority scheduler
`default_nettype none

package ppsch_pkg;

   localparam int SLOTS_DEFAULT = 16;

   localparam int TIME_W   = 32;
   localparam int ID_W     = 8;
   localparam int BURST_W  = 16;
   localparam int PRIO_W   = 8;
   localparam int STATUS_W = 2;

   localparam logic OP_ADMIT = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_ADMITTED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RAN      = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_IDLE     = 2'd3;

   typedef struct packed {
      logic [ID_W-1:0]    job_id;
      logic [PRIO_W-1:0]  priority_val;
      logic [TIME_W-1:0]  arrival;
      logic [BURST_W-1:0] burst;
      logic [BURST_W-1:0] remaining;
      logic               started;
      logic [TIME_W-1:0]  start_time;
   } slot_data_type;

   function automatic logic [TIME_W-1:0] sat_inc(input logic [TIME_W-1:0] v);
      return (v == {TIME_W{1'b1}}) ? v : v + 1'b1;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/ppsch_cell.sv =====
// one job slot of the rotating slot ring
`default_nettype none

module ppsch_cell import ppsch_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          shift_en,
   input  wire logic          prev_valid,
   input  wire slot_data_type prev_data,
   input  wire logic          wr_en,
   input  wire logic          wr_valid,
   input  wire slot_data_type wr_data,
   output      logic          valid,
   output      slot_data_type data
);

   logic          valid_ff, valid_in;
   slot_data_type data_ff, data_in;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (shift_en) begin
         valid_in = prev_valid;
         data_in  = prev_data;
      end else if (wr_en) begin
         valid_in = wr_valid;
         data_in  = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign valid = valid_ff;
   assign data  = data_ff;

endmodule

`default_nettype wire

// ===== hdl/ppsch_pick.sv =====
// running best-slot compare at the head of the ring
`default_nettype none

module ppsch_pick import ppsch_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT,
   localparam int IDX_W = $clog2(SLOTS)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              clear,
   input  wire logic              step,
   input  wire logic              head_valid,
   input  wire logic [PRIO_W-1:0] head_priority,
   input  wire logic [TIME_W-1:0] head_arrival,
   input  wire logic [IDX_W-1:0]  head_idx,
   output      logic              best_found,
   output      logic [IDX_W-1:0]  best_idx
);

   logic              found_ff, found_in;
   logic [PRIO_W-1:0] prio_ff, prio_in;
   logic [TIME_W-1:0] arr_ff, arr_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              better;

   // strict compare keeps the lower slot on a full tie
   assign better = head_valid && (!found_ff || (head_priority < prio_ff) ||
                   ((head_priority == prio_ff) && (head_arrival < arr_ff)));

   always_comb begin
      found_in = found_ff;
      prio_in  = prio_ff;
      arr_in   = arr_ff;
      idx_in   = idx_ff;
      if (clear) begin
         found_in = 1'b0;
      end else if (step && better) begin
         found_in = 1'b1;
         prio_in  = head_priority;
         arr_in   = head_arrival;
         idx_in   = head_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      prio_ff <= prio_in;
      arr_ff  <= arr_in;
      idx_ff  <= idx_in;
   end

   assign best_found = found_ff;
   assign best_idx   = idx_ff;

endmodule

`default_nettype wire

// ===== hdl/preemptive_priority_scheduler.sv =====
// top level of the preemptive priority scheduler
//
// Requests arrive on req_* (valid/ready), one result per request leaves on
// rsp_* (valid/ready). An admit stores the job in the lowest free slot and
// stamps the current time, or is rejected on a full table or a zero burst; a
// tick runs the best valid job for one time unit. Slots live in a ring of
// SLOTS cells. A tick rotates the ring once through the compare unit at its
// head, one slot per cycle, then reads the winner and writes it back.
// Sequence: an admit goes from the idle state straight to the done state; a
// tick goes through the scan state, which visits every slot, then the load
// state and the done state. The result register and any slot update are
// written in the done state, and the next request is taken back in the idle
// state. One request is in flight at a time; a new request transfer is taken
// while the previous result still waits in the output register. If the
// receiver stalls, the result holds in the output register and the block
// finishes its current request, then waits before writing the next result.
// Reset empties all slots, clears the time counter and drops rsp_valid;
// the block takes a request in the first cycle after reset.
`default_nettype none

module preemptive_priority_scheduler import ppsch_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_ready,
   input  wire logic                req_opcode,
   input  wire logic [ID_W-1:0]     req_job_id,
   input  wire logic [BURST_W-1:0]  req_job_burst,
   input  wire logic [PRIO_W-1:0]   req_job_priority,
   output      logic                rsp_valid,
   input  wire logic                rsp_ready,
   output      logic [STATUS_W-1:0] rsp_status,
   output      logic [ID_W-1:0]     rsp_run_id,
   output      logic [TIME_W-1:0]   rsp_tick_time,
   output      logic                rsp_finished,
   output      logic [TIME_W-1:0]   rsp_turnaround_time,
   output      logic [TIME_W-1:0]   rsp_waiting_time,
   output      logic [TIME_W-1:0]   rsp_response_time
);

   localparam int IDX_W = $clog2(SLOTS);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_LOAD = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic               op_ff;
   logic [ID_W-1:0]    id_ff;
   logic [BURST_W-1:0] burst_ff;
   logic [PRIO_W-1:0]  prio_ff;
   logic [TIME_W-1:0]  time_ff, time_in;
   logic [TIME_W-1:0]  next_time_ff;
   logic [IDX_W-1:0]   scan_cnt_ff, scan_cnt_in;
   slot_data_type      win_ff;
   logic               win_found_ff;
   logic [IDX_W-1:0]   win_idx_ff;

   logic               cell_valid [SLOTS];
   slot_data_type      cell_data  [SLOTS];
   logic               req_xfer;
   logic               shift_en;
   logic               out_free;
   logic               done_fire;
   logic               best_found;
   logic [IDX_W-1:0]   best_idx;

   logic               free_found;
   logic [IDX_W-1:0]   free_idx;

   logic               wr_do;
   logic [IDX_W-1:0]   wr_sel;
   logic               wr_valid;
   slot_data_type      wr_data;
   slot_data_type      upd;
   logic [TIME_W-1:0]  turn;

   logic [STATUS_W-1:0] status_in;
   logic [ID_W-1:0]     run_id_in;
   logic                finished_in;
   logic [TIME_W-1:0]   turn_in, wait_in, resp_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [ID_W-1:0]     rsp_run_id_ff;
   logic [TIME_W-1:0]   rsp_tick_time_ff;
   logic                rsp_finished_ff;
   logic [TIME_W-1:0]   rsp_turn_ff, rsp_wait_ff, rsp_resp_ff;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign shift_en  = (state_ff == ST_SCAN);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign done_fire = (state_ff == ST_DONE) && out_free;

   // slot ring, each cell takes its upper neighbor on a shift
   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      ppsch_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (shift_en),
         .prev_valid (cell_valid[(i + 1) % SLOTS]),
         .prev_data  (cell_data[(i + 1) % SLOTS]),
         .wr_en      (done_fire && wr_do && (wr_sel == IDX_W'(i))),
         .wr_valid   (wr_valid),
         .wr_data    (wr_data),
         .valid      (cell_valid[i]),
         .data       (cell_data[i])
      );
   end

   ppsch_pick #(.SLOTS(SLOTS)) u_pick (
      .clock         (clock),
      .reset         (reset),
      .clear         (req_xfer),
      .step          (shift_en),
      .head_valid    (cell_valid[0]),
      .head_priority (cell_data[0].priority_val),
      .head_arrival  (cell_data[0].arrival),
      .head_idx      (scan_cnt_ff),
      .best_found    (best_found),
      .best_idx      (best_idx)
   );

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!cell_valid[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   always_comb begin
      state_in    = state_ff;
      scan_cnt_in = scan_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               scan_cnt_in = '0;
               state_in    = (req_opcode == OP_TICK) ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            scan_cnt_in = scan_cnt_ff + 1'b1;
            if (scan_cnt_ff == IDX_W'(SLOTS - 1)) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result and slot update
   always_comb begin
      status_in   = STATUS_IDLE;
      run_id_in   = '0;
      finished_in = 1'b0;
      turn_in     = '0;
      wait_in     = '0;
      resp_in     = '0;
      time_in     = time_ff;
      wr_do       = 1'b0;
      wr_sel      = win_idx_ff;
      wr_valid    = 1'b1;
      wr_data     = win_ff;
      upd         = win_ff;
      turn        = next_time_ff - win_ff.arrival;
      if (op_ff == OP_ADMIT) begin
         if (free_found && (burst_ff != '0)) begin
            status_in = STATUS_ADMITTED;
            wr_do     = 1'b1;
            wr_sel    = free_idx;
            wr_data   = '{job_id: id_ff, priority_val: prio_ff, arrival: time_ff,
                          burst: burst_ff, remaining: burst_ff, started: 1'b0,
                          start_time: '0};
         end else begin
            status_in = STATUS_REJECTED;
         end
      end else begin
         time_in = next_time_ff;
         if (win_found_ff) begin
            status_in = STATUS_RAN;
            run_id_in = win_ff.job_id;
            if (!win_ff.started) begin
               upd.started    = 1'b1;
               upd.start_time = time_ff;
            end
            if (win_ff.remaining != '0) begin
               upd.remaining = win_ff.remaining - 1'b1;
            end
            wr_do   = 1'b1;
            wr_data = upd;
            if (upd.remaining == '0) begin
               wr_valid    = 1'b0;
               finished_in = 1'b1;
               turn_in     = turn;
               wait_in     = (turn >= TIME_W'(win_ff.burst)) ?
                             turn - TIME_W'(win_ff.burst) : '0;
               resp_in     = upd.start_time - win_ff.arrival;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         time_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (done_fire) begin
            time_ff <= time_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_cnt_ff <= scan_cnt_in;
      if (req_xfer) begin
         op_ff    <= req_opcode;
         id_ff    <= req_job_id;
         burst_ff <= req_job_burst;
         prio_ff  <= req_job_priority;
      end
      if (state_ff == ST_LOAD) begin
         win_ff       <= cell_data[best_idx];
         win_found_ff <= best_found;
         win_idx_ff   <= best_idx;
         next_time_ff <= sat_inc(time_ff);
      end
      if (done_fire) begin
         rsp_status_ff    <= status_in;
         rsp_run_id_ff    <= run_id_in;
         rsp_tick_time_ff <= time_ff;
         rsp_finished_ff  <= finished_in;
         rsp_turn_ff      <= turn_in;
         rsp_wait_ff      <= wait_in;
         rsp_resp_ff      <= resp_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_run_id          = rsp_run_id_ff;
   assign rsp_tick_time       = rsp_tick_time_ff;
   assign rsp_finished        = rsp_finished_ff;
   assign rsp_turnaround_time = rsp_turn_ff;
   assign rsp_waiting_time    = rsp_wait_ff;
   assign rsp_response_time   = rsp_resp_ff;

endmodule

`default_nettype wire

// ===== hdl/ppsch_checker.sv =====
// port-level checks for the preemptive priority scheduler, bound to the top
`default_nettype none

`include "assert_macros.svh"

module ppsch_checker import ppsch_pkg::*; (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [STATUS_W-1:0] rsp_status,
   input wire logic [ID_W-1:0]     rsp_run_id,
   input wire logic [TIME_W-1:0]   rsp_tick_time,
   input wire logic                rsp_finished,
   input wire logic [TIME_W-1:0]   rsp_turnaround_time,
   input wire logic [TIME_W-1:0]   rsp_waiting_time,
   input wire logic [TIME_W-1:0]   rsp_response_time
);

   // stalled result holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_status) && $stable(rsp_tick_time) && $stable(rsp_run_id))

   // one request in flight
   `ASSERT_NEXT(a_one_inflight, clock, reset, req_valid && req_ready, !req_ready)

   // only a run job can finish
   `ASSERT_SAME(a_finish_ran, clock, reset, rsp_valid && rsp_finished,
      rsp_status == STATUS_RAN)

   // no run id unless a job ran
   `ASSERT_SAME(a_run_id_zero, clock, reset, rsp_valid && (rsp_status != STATUS_RAN),
      (rsp_run_id == '0) && !rsp_finished)

   // waiting and response never exceed turnaround
   `ASSERT_SAME(a_wait_le_turn, clock, reset, rsp_valid && rsp_finished,
      (rsp_waiting_time <= rsp_turnaround_time) &&
      (rsp_response_time <= rsp_turnaround_time))

endmodule

bind preemptive_priority_scheduler ppsch_checker u_ppsch_checker (.*);

`default_nettype wire

// ===== tb/preemptive_priority_scheduler_tb.sv =====
// testbench for the preemptive priority scheduler: queued stimulus, shadow scheduler, result checks
`default_nettype none

module preemptive_priority_scheduler_tb;
   import ppsch_pkg::*;

   localparam int SLOTS   = SLOTS_DEFAULT;
   localparam int PLAN    = 0;
   localparam int CHECK   = 1;
   localparam int N_RAND  = 1900;
   localparam int TIMEOUT = 4000000;

   typedef struct packed {
      logic               opcode;
      logic [ID_W-1:0]    job_id;
      logic [BURST_W-1:0] burst;
      logic [PRIO_W-1:0]  prio;
      logic               wait_drain;
   } sched_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     run_id;
      logic [TIME_W-1:0]   tick_time;
      logic                finished;
      logic [TIME_W-1:0]   turnaround;
      logic [TIME_W-1:0]   waiting;
      logic [TIME_W-1:0]   response;
   } sched_rsp_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_opcode = OP_ADMIT;
   logic [ID_W-1:0]     req_job_id = '0;
   logic [BURST_W-1:0]  req_job_burst = '0;
   logic [PRIO_W-1:0]   req_job_priority = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [ID_W-1:0]     rsp_run_id;
   logic [TIME_W-1:0]   rsp_tick_time;
   logic                rsp_finished;
   logic [TIME_W-1:0]   rsp_turnaround_time;
   logic [TIME_W-1:0]   rsp_waiting_time;
   logic [TIME_W-1:0]   rsp_response_time;

   preemptive_priority_scheduler #(.SLOTS(SLOTS)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_job_id(req_job_id),
      .req_job_burst(req_job_burst),
      .req_job_priority(req_job_priority),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_run_id(rsp_run_id),
      .rsp_tick_time(rsp_tick_time),
      .rsp_finished(rsp_finished),
      .rsp_turnaround_time(rsp_turnaround_time),
      .rsp_waiting_time(rsp_waiting_time),
      .rsp_response_time(rsp_response_time)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // two copies of the slot table: one steers stimulus, one checks the block
   logic               slot_live    [2][SLOTS];
   logic [ID_W-1:0]    slot_id      [2][SLOTS];
   logic [PRIO_W-1:0]  slot_prio    [2][SLOTS];
   logic [TIME_W-1:0]  slot_arrival [2][SLOTS];
   logic [BURST_W-1:0] slot_burst   [2][SLOTS];
   logic [BURST_W-1:0] slot_left    [2][SLOTS];
   logic               slot_started [2][SLOTS];
   logic [TIME_W-1:0]  slot_start   [2][SLOTS];
   logic [TIME_W-1:0]  sched_time   [2];

   sched_req_type pending_req_q[$];
   sched_rsp_type expected_rsp_q[$];
   sched_req_type cur_req;

   int item_total = 0;
   int accepted_count = 0;
   int result_count = 0;
   int fail_count = 0;
   int gap_left = 0;
   int burst_left = 1;
   int hold_left = 0;
   int ready_mode = 0;
   int mode_left = 0;
   bit hold_done = 1'b0;

   function automatic sched_rsp_type schedule_item(input int m, input sched_req_type r);
      sched_rsp_type e;
      int pick;
      logic [TIME_W-1:0] now;
      logic [TIME_W-1:0] done;
      logic [TIME_W-1:0] turn;
      e = '0;
      now = sched_time[m];
      e.tick_time = now;
      if (r.opcode == OP_ADMIT) begin
         pick = SLOTS;
         for (int i = SLOTS - 1; i >= 0; i--)
            if (!slot_live[m][i]) pick = i;
         if (pick == SLOTS || r.burst == '0) begin
            e.status = STATUS_REJECTED;
         end else begin
            slot_live[m][pick]    = 1'b1;
            slot_id[m][pick]      = r.job_id;
            slot_prio[m][pick]    = r.prio;
            slot_arrival[m][pick] = now;
            slot_burst[m][pick]   = r.burst;
            slot_left[m][pick]    = r.burst;
            slot_started[m][pick] = 1'b0;
            slot_start[m][pick]   = '0;
            e.status = STATUS_ADMITTED;
         end
      end else begin
         pick = SLOTS;
         for (int i = 0; i < SLOTS; i++)
            if (slot_live[m][i] && (pick == SLOTS ||
                slot_prio[m][i] < slot_prio[m][pick] ||
                (slot_prio[m][i] == slot_prio[m][pick] &&
                 slot_arrival[m][i] < slot_arrival[m][pick])))
               pick = i;
         if (pick == SLOTS) begin
            e.status = STATUS_IDLE;
         end else begin
            e.status = STATUS_RAN;
            e.run_id = slot_id[m][pick];
            if (!slot_started[m][pick]) begin
               slot_started[m][pick] = 1'b1;
               slot_start[m][pick]   = now;
            end
            if (slot_left[m][pick] != '0) slot_left[m][pick] = slot_left[m][pick] - 1'b1;
            if (slot_left[m][pick] == '0) begin
               done = (now == '1) ? now : now + 1'b1;
               turn = done - slot_arrival[m][pick];
               e.finished   = 1'b1;
               e.turnaround = turn;
               e.waiting    = (turn >= TIME_W'(slot_burst[m][pick])) ?
                              turn - TIME_W'(slot_burst[m][pick]) : '0;
               e.response   = slot_start[m][pick] - slot_arrival[m][pick];
               slot_live[m][pick] = 1'b0;
            end
         end
         sched_time[m] = (now == '1) ? now : now + 1'b1;
      end
      return e;
   endfunction

   task automatic queue_item(input logic op, input logic [ID_W-1:0] id,
                             input logic [BURST_W-1:0] burst, input logic [PRIO_W-1:0] prio,
                             input logic drain);
      sched_req_type it;
      it.opcode     = op;
      it.job_id     = id;
      it.burst      = burst;
      it.prio       = prio;
      it.wait_drain = drain;
      pending_req_q.insert(pending_req_q.size(), it);
      void'(schedule_item(PLAN, it));
      item_total++;
   endtask

   task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                              input logic [TIME_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   // request driver
   always @(posedge clock) begin
      sched_req_type nxt;
      logic send;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_rsp_q.insert(expected_rsp_q.size(), schedule_item(CHECK, cur_req));
            accepted_count++;
         end
         if (!req_valid || req_ready) begin
            send = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_req_q.size() > 0 &&
                         !(pending_req_q[0].wait_drain && expected_rsp_q.size() > 0)) begin
               nxt = pending_req_q.pop_front();
               cur_req = nxt;
               send = 1'b1;
               req_opcode       <= nxt.opcode;
               req_job_id       <= nxt.job_id;
               req_job_burst    <= nxt.burst;
               req_job_priority <= nxt.prio;
               burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 30);
                  gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
               end
            end
            req_valid <= send;
         end
      end
   end

   // result receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && result_count >= 400) begin
         hold_done = 1'b1;
         hold_left = 600;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         case (ready_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // result monitor
   always @(posedge clock) begin
      sched_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         result_count++;
         if (expected_rsp_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual status %0d",
                     $time, rsp_status);
            fail_count++;
         end else begin
            want = expected_rsp_q.pop_front();
            check_field("status", TIME_W'(want.status), TIME_W'(rsp_status));
            check_field("run_id", TIME_W'(want.run_id), TIME_W'(rsp_run_id));
            check_field("tick_time", want.tick_time, rsp_tick_time);
            check_field("finished", TIME_W'(want.finished), TIME_W'(rsp_finished));
            check_field("turnaround_time", want.turnaround, rsp_turnaround_time);
            check_field("waiting_time", want.waiting, rsp_waiting_time);
            check_field("response_time", want.response, rsp_response_time);
         end
      end
   end

   initial begin
      int admit_pct;
      int live;
      int roll;
      logic drain;
      logic [BURST_W-1:0] burst;
      logic [PRIO_W-1:0] prio;
      for (int m = 0; m < 2; m++) begin
         sched_time[m] = '0;
         for (int i = 0; i < SLOTS; i++) slot_live[m][i] = 1'b0;
      end

      // idle tick, zero burst, tie on priority and arrival, preemption
      queue_item(OP_TICK, 8'd0, 16'd0, 8'd0, 1'b0);
      queue_item(OP_ADMIT, 8'd7, 16'd0, 8'd3, 1'b0);
      queue_item(OP_ADMIT, 8'd1, 16'd2, 8'd5, 1'b0);
      queue_item(OP_ADMIT, 8'd1, 16'd1, 8'd5, 1'b0);
      queue_item(OP_TICK, 8'd0, 16'd0, 8'd0, 1'b0);
      queue_item(OP_ADMIT, 8'd2, 16'd1, 8'd0, 1'b0);
      queue_item(OP_TICK, 8'd0, 16'd0, 8'd0, 1'b0);
      queue_item(OP_TICK, 8'd0, 16'd0, 8'd0, 1'b0);
      queue_item(OP_TICK, 8'd0, 16'd0, 8'd0, 1'b0);
      // fill the table, then offer to a full table
      for (int i = 0; i < SLOTS; i++)
         queue_item(OP_ADMIT, 8'(i * 17), 16'(1 + i % 3), (i % 2) ? 8'hFF : 8'h00, 1'b0);
      queue_item(OP_ADMIT, 8'hAA, 16'hFFFF, 8'h00, 1'b0);

      admit_pct = 45;
      for (int n = 0; n < N_RAND; n++) begin
         if (n % 200 == 0) admit_pct = (admit_pct == 15) ? 45 : 15;
         drain = (n % 350 == 0);
         live = 0;
         for (int i = 0; i < SLOTS; i++) live += slot_live[PLAN][i];
         if (live == SLOTS) begin
            if ($urandom_range(0, 3) == 0)
               queue_item(OP_ADMIT, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                          8'($urandom_range(0, 255)), drain);
            else
               queue_item(OP_TICK, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                          8'($urandom_range(0, 255)), drain);
         end else if ($urandom_range(0, 99) < admit_pct) begin
            roll = $urandom_range(0, 99);
            if (roll < 4) burst = '0;
            else if (roll < 90) burst = 16'($urandom_range(1, 6));
            else burst = 16'($urandom_range(1, 40));
            prio = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 3));
            queue_item(OP_ADMIT, 8'($urandom_range(0, 255)), burst, prio, drain);
         end else begin
            queue_item(OP_TICK, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                       8'($urandom_range(0, 255)), drain);
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count != item_total) @(posedge clock);
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (3 * SLOTS) @(posedge clock);
      if (fail_count == 0)
         $display("** preemptive_priority_scheduler: PASSED **");
      else
         $display("** preemptive_priority_scheduler: FAILED **");
      $finish;
   end

   initial begin
      #TIMEOUT;
      $display("** preemptive_priority_scheduler: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+hdl
hdl/ppsch_pkg.sv
hdl/ppsch_cell.sv
hdl/ppsch_pick.sv
hdl/preemptive_priority_scheduler.sv
hdl/ppsch_checker.sv
tb/preemptive_priority_scheduler_tb.sv
